[hw/rtl/swmms_pkg.sv]
// Shared widths and lane control type for the sliding window statistics block.
package swmms_pkg;

  localparam int SAMPLE_W = 16;
  localparam int SUM_W    = 24;
  localparam int FILL_W   = 8;
  localparam int EVICT_W  = 16;
  localparam int IN_W     = 2 * SAMPLE_W;
  localparam int OUT_W    = FILL_W + 2 * SUM_W + 4 * SAMPLE_W + EVICT_W;

  // Per-cycle commands from the sequencer to each channel lane
  typedef struct packed {
    logic load;        // capture the incoming sample
    logic rd_en;       // read window entry at addr
    logic wr_en;       // write captured sample at addr
    logic update;      // fold sample into sum and extremes; evicted entry leaves the sum
    logic evict;       // window full: read data is the entry being replaced
    logic first;       // window was empty: sample sets both extremes
    logic take;        // read data is a rescan entry
    logic take_first;  // read data is the first rescan entry
  } lane_ctl_t;

endpackage

[hw/rtl/swmms_lane.sv]
// One channel lane: window memory, running sum and min/max tracking.
module swmms_lane #(
  parameter int WINDOW = 128,
  parameter int AW     = 7
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  swmms_pkg::lane_ctl_t                  ctl,
  input  logic [AW-1:0]                         addr,
  input  logic signed [swmms_pkg::SAMPLE_W-1:0] sample,
  output logic signed [swmms_pkg::SUM_W-1:0]    sum,
  output logic signed [swmms_pkg::SAMPLE_W-1:0] mn,
  output logic signed [swmms_pkg::SAMPLE_W-1:0] mx,
  output logic                                  hit
);

  localparam int DW = swmms_pkg::SAMPLE_W;
  localparam int SW = swmms_pkg::SUM_W;

  logic signed [DW-1:0] mem [WINDOW];
  logic signed [DW-1:0] rd_data;
  logic signed [DW-1:0] smp;
  logic signed [SW-1:0] sum_next;

  // Window storage, registered read
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[addr] <= smp;
    end
    if (ctl.rd_en) begin
      rd_data <= mem[addr];
    end
  end

  // Sample capture
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      smp <= sample;
    end
  end

  // Evicted entry matches a tracked extreme
  assign hit = ctl.evict && ((rd_data == mn) || (rd_data == mx));

  // Remove evicted entry, add new sample; wraps at the sum width
  always_comb begin
    sum_next = sum + SW'(smp);
    if (ctl.evict) begin
      sum_next = sum_next - SW'(rd_data);
    end
  end

  // Sum and extremes
  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
      mn  <= '0;
      mx  <= '0;
    end else begin
      if (ctl.update) begin
        sum <= sum_next;
        if (ctl.first) begin
          mn <= smp;
          mx <= smp;
        end else begin
          if (smp < mn) mn <= smp;
          if (smp > mx) mx <= smp;
        end
      end else if (ctl.take) begin
        // rescan overrides whatever the update left
        if (ctl.take_first) begin
          mn <= rd_data;
          mx <= rd_data;
        end else begin
          if (rd_data < mn) mn <= rd_data;
          if (rd_data > mx) mx <= rd_data;
        end
      end
    end
  end

endmodule

[hw/rtl/sliding_window_min_max_sum.sv]
// Sliding window statistics top level: request sequencer, two channel lanes, result merge.
//
// Each request carries one temperature and one humidity sample; a lane per channel holds
// that channel's WINDOW-entry ring, its running sum and its minimum and maximum, and the
// merge stage combines the lanes' eviction checks and packs one result per request. A
// request normally goes from acceptance through the update state to the result. When the
// window is full and the evicted entry of either channel equals one of that channel's
// extremes, both lanes rescan their whole window through the single memory read port, one
// entry per cycle, followed by a drain state. A new request is taken while the previous
// result still waits in the output register.
module sliding_window_min_max_sum #(
  parameter int WINDOW = 128
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // temperature [15:0], humidity [31:16]
  input  logic [swmms_pkg::IN_W-1:0]    s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // fill_count [7:0], temperature_sum [31:8], humidity_sum [55:32],
  // temperature_min [71:56], temperature_max [87:72], humidity_min [103:88],
  // humidity_max [119:104], overwrite_total [135:120]
  output logic [swmms_pkg::OUT_W-1:0]   m_tdata
);

  localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CW = $clog2(WINDOW + 1);
  localparam int DW = swmms_pkg::SAMPLE_W;
  localparam int SW = swmms_pkg::SUM_W;
  localparam int FW = swmms_pkg::FILL_W;
  localparam int EW = swmms_pkg::EVICT_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  state_t               state;
  logic [AW-1:0]        wr_pos;
  logic [AW-1:0]        cnt;
  logic [CW-1:0]        held;
  logic [EW-1:0]        evictions;
  logic                 take;
  logic                 take_first;
  logic                 full;
  logic                 in_acc;
  logic                 hit_any;
  logic [AW-1:0]        addr;
  swmms_pkg::lane_ctl_t ctl;

  logic signed [SW-1:0] t_sum, h_sum;
  logic signed [DW-1:0] t_mn, t_mx, h_mn, h_mx;
  logic                 t_hit, h_hit;

  assign full     = (held == CW'(WINDOW));
  assign s_tready = (state == ST_IDLE);
  assign in_acc   = s_tvalid && s_tready;
  assign hit_any  = t_hit || h_hit;
  assign addr     = (state == ST_SCAN) ? cnt : wr_pos;

  // Lane commands
  always_comb begin
    ctl            = '0;
    ctl.take       = take;
    ctl.take_first = take_first;
    case (state)
      ST_IDLE: begin
        ctl.load  = in_acc;
        ctl.rd_en = in_acc;
      end
      ST_UPDATE: begin
        ctl.wr_en  = 1'b1;
        ctl.update = 1'b1;
        ctl.evict  = full;
        ctl.first  = (held == '0);
      end
      ST_SCAN: begin
        ctl.rd_en = 1'b1;
      end
      default: ;
    endcase
  end

  swmms_lane #(.WINDOW(WINDOW), .AW(AW)) u_temp_lane (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .addr   (addr),
    .sample (s_tdata[DW-1:0]),
    .sum    (t_sum),
    .mn     (t_mn),
    .mx     (t_mx),
    .hit    (t_hit)
  );

  swmms_lane #(.WINDOW(WINDOW), .AW(AW)) u_hum_lane (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .addr   (addr),
    .sample (s_tdata[2*DW-1:DW]),
    .sum    (h_sum),
    .mn     (h_mn),
    .mx     (h_mx),
    .hit    (h_hit)
  );

  // Sequencer, counters and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      wr_pos     <= '0;
      cnt        <= '0;
      held       <= '0;
      evictions  <= '0;
      take       <= 1'b0;
      take_first <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      take       <= (state == ST_SCAN);
      take_first <= (state == ST_SCAN) && (cnt == '0);
      // result taken; in ST_EMIT the next result replaces it below
      if (m_tvalid && m_tready && (state != ST_EMIT)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            state <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          if (full) begin
            evictions <= evictions + 1'b1;
          end else begin
            held <= held + 1'b1;
          end
          wr_pos <= (wr_pos == AW'(WINDOW - 1)) ? '0 : wr_pos + 1'b1;
          cnt    <= '0;
          state  <= hit_any ? ST_SCAN : ST_EMIT;
        end
        ST_SCAN: begin
          if (cnt == AW'(WINDOW - 1)) begin
            state <= ST_DRAIN;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_DRAIN: begin
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {evictions, h_mx, h_mn, t_mx, t_mn, h_sum, t_sum, FW'(held)};
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Checks
  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    held <= CW'(WINDOW))
    else $error("fill count above window size");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    wr_pos <= AW'(WINDOW - 1))
    else $error("write position outside window");

  a_scan_full: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> full)
    else $error("rescan started before window filled");

  a_no_hit_emit: assert property (@(posedge clk) disable iff (rst)
    state == ST_UPDATE && !hit_any |=> state == ST_EMIT)
    else $error("update without extreme hit did not go to result");

  a_evict_hold: assert property (@(posedge clk) disable iff (rst)
    state == ST_UPDATE && !full |=> $stable(evictions))
    else $error("eviction counted while window not full");

endmodule
